### rtl/sitda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sitda_pkg;

  // Input word and decimal layout
  localparam int ValueW    = 32;
  localparam int NumDigits = 10;
  localparam int DigitW    = 4;
  localparam int BcdW      = NumDigits * DigitW;
  localparam int IdxW      = 4;
  localparam int CharW     = 8;

  // Double dabble retires two input bits per conversion cycle
  localparam int BitsPerStep = 2;
  localparam int ConvSteps   = ValueW / BitsPerStep;
  localparam int ConvCntW    = 4;

  // ASCII codes
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharMinus = 8'h2D;

  // Classified item passed from the front to the back
  typedef struct packed {
    logic              neg;
    logic [ValueW-1:0] mag;
  } item_t;

endpackage

`default_nettype wire

### rtl/signed_int_to_decimal_ascii_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Converts a 32-bit two's complement integer into its decimal ASCII text, one
// character per result: an optional '-' followed by the digits, most
// significant first, with no leading zeros ('0' for zero); last_char_o marks
// the final character. Both sides look like a queue (push/full in,
// empty/pop out). A two-entry queue after the input classifier takes new
// numbers while the converter works. The converter takes one number at a time:
// it loads the number, runs a double dabble of two bits per cycle, finds the
// leading digit in StLead, then hands out one character per cycle while the
// result side pops without stalls, and takes the next number only after the
// last character of the current one has been handed out.
module signed_int_to_decimal_ascii_core import sitda_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic signed [ValueW-1:0] value_i,
  output logic                          empty,
  input  wire logic                     pop,
  output logic [CharW-1:0]              text_char_o,
  output logic                          last_char_o
);

  logic  item_valid;
  logic  item_take;
  item_t item;

  sitda_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .value_i      (value_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  sitda_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .empty        (empty),
    .pop          (pop),
    .text_char_o  (text_char_o),
    .last_char_o  (last_char_o)
  );

endmodule

`default_nettype wire

### rtl/sitda_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sitda_front import sitda_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [ValueW-1:0] value_i,
  output logic                   item_valid_o,
  output item_t                  item_o,
  input  wire logic              item_take_i
);

  localparam int Depth = 2;

  item_t       entries_q [Depth];
  logic        wr_ptr_q;
  logic        rd_ptr_q;
  logic [1:0]  count_q;
  logic        wr_en;
  logic        rd_en;
  item_t       item_in;

  // Classify: split sign and form the unsigned magnitude
  always_comb begin
    item_in.neg = value_i[ValueW-1];
    item_in.mag = item_in.neg ? (ValueW'(0) - value_i) : value_i;
  end

  assign full         = (count_q == 2'(Depth));
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = entries_q[rd_ptr_q];
  assign wr_en        = push && !full;
  assign rd_en        = item_take_i && item_valid_o;

  // Store accepted items
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entries_q[wr_ptr_q] <= item_in;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_q <= ~wr_ptr_q;
      if (rd_en) rd_ptr_q <= ~rd_ptr_q;
      case ({wr_en, rd_en})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/sitda_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sitda_back import sitda_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             item_valid_i,
  input  wire item_t            item_i,
  output logic                  item_take_o,
  output logic                  empty,
  input  wire logic             pop,
  output logic [CharW-1:0]      text_char_o,
  output logic                  last_char_o
);

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StLead,
    StEmit
  } state_e;

  state_e              state_q, state_d;
  logic [ValueW-1:0]   shift_q, shift_d;
  logic [BcdW-1:0]     bcd_q, bcd_d;
  logic [ConvCntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic                sign_q, sign_d;
  logic                out_valid_q, out_valid_d;
  logic [CharW-1:0]    char_q, char_d;
  logic                last_q, last_d;
  logic [IdxW-1:0]     top_idx;
  logic [DigitW-1:0]   cur_digit;
  logic                slot_free;

  // One double dabble step: correct each digit, then shift in a bit
  function automatic logic [BcdW-1:0] dabble(input logic [BcdW-1:0] bcd, input logic bit_in);
    logic [BcdW-1:0] adj;
    adj = bcd;
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd[i*DigitW +: DigitW] >= 4'd5) begin
        adj[i*DigitW +: DigitW] = bcd[i*DigitW +: DigitW] + 4'd3;
      end
    end
    return {adj[BcdW-2:0], bit_in};
  endfunction

  // Find the most significant nonzero digit; zero keeps the ones digit
  always_comb begin
    top_idx = '0;
    for (int i = 1; i < NumDigits; i++) begin
      if (bcd_q[i*DigitW +: DigitW] != 4'd0) begin
        top_idx = IdxW'(i);
      end
    end
  end

  assign cur_digit   = bcd_q[{idx_q, 2'b00} +: DigitW];
  assign slot_free   = !out_valid_q || pop;
  assign item_take_o = (state_q == StIdle) && item_valid_i;
  assign empty       = !out_valid_q;
  assign text_char_o = char_q;
  assign last_char_o = last_q;

  // Next state and output register
  always_comb begin
    state_d     = state_q;
    shift_d     = shift_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    sign_d      = sign_q;
    char_d      = char_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !pop;

    case (state_q)
      StIdle: begin
        if (item_valid_i) begin
          shift_d = item_i.mag;
          sign_d  = item_i.neg;
          bcd_d   = '0;
          cnt_d   = ConvCntW'(ConvSteps - 1);
          state_d = StConv;
        end
      end
      StConv: begin
        bcd_d   = dabble(dabble(bcd_q, shift_q[ValueW-1]), shift_q[ValueW-2]);
        shift_d = {shift_q[ValueW-BitsPerStep-1:0], {BitsPerStep{1'b0}}};
        cnt_d   = cnt_q - ConvCntW'(1);
        if (cnt_q == '0) begin
          state_d = StLead;
        end
      end
      StLead: begin
        // Start the digit walk at the leading digit of the finished BCD word
        idx_d   = top_idx;
        state_d = StEmit;
      end
      StEmit: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          if (sign_q) begin
            char_d = CharMinus;
            last_d = 1'b0;
            sign_d = 1'b0;
          end else begin
            char_d = CharZero + CharW'(cur_digit);
            last_d = (idx_q == '0);
            if (idx_q == '0) begin
              state_d = StIdle;
            end else begin
              idx_d = idx_q - IdxW'(1);
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Hold state, datapath and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      idx_q       <= '0;
      sign_q      <= 1'b0;
      shift_q     <= '0;
      bcd_q       <= '0;
      char_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      sign_q      <= sign_d;
      shift_q     <= shift_d;
      bcd_q       <= bcd_d;
      char_q      <= char_d;
      last_q      <= last_d;
    end
  end

endmodule

`default_nettype wire

### rtl/sitda_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sitda_checker import sitda_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             empty,
  input wire logic             pop,
  input wire logic [CharW-1:0] text_char_o,
  input wire logic             last_char_o
);

  // Shown characters are only a minus sign or a decimal digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (text_char_o == CharMinus) ||
               ((text_char_o >= CharZero) && (text_char_o <= CharZero + 8'd9)))
    else $error("result character is neither minus nor digit");

  // A minus sign never ends a number's text
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (text_char_o == CharMinus)) |-> !last_char_o)
    else $error("minus sign marked as last character");

  // A stalled result stays on the ports
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(text_char_o) && $stable(last_char_o)))
    else $error("stalled result changed");

  // A transferred minus sign is followed by a digit, never another minus
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && (text_char_o == CharMinus)) |=> (empty || (text_char_o != CharMinus)))
    else $error("minus sign repeated");

endmodule

bind signed_int_to_decimal_ascii_core sitda_checker u_sitda_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .empty       (empty),
  .pop         (pop),
  .text_char_o (text_char_o),
  .last_char_o (last_char_o)
);

`default_nettype wire
